// ----- design/lkvc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types for the LRU key/value cache
// Request and response words, the command code, and the structs that run
// between neighboring cells of the recency chain.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  // Reset value of the capacity register
  localparam logic [CapW-1:0] CapReset = 5'd16;

  // Register index of the capacity register
  localparam logic RegCapacity = 1'b0;

  // Read value reported on a get miss
  localparam logic signed [DataW-1:0] MissValue = -32'sd1;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [DataW-1:0] key;
    logic signed [DataW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    hit;
    logic signed [DataW-1:0] read_value;
    logic                    evicted;
    logic signed [DataW-1:0] evicted_key;
  } rsp_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic             go;     // update the chain this cycle
    logic             hit;    // key found somewhere in the chain
    logic             evict;  // put of a new key with the chain at capacity
    logic [DataW-1:0] key;    // key under lookup
  } ctl_t;

  // Link from one cell to its neighbor toward least-recent
  typedef struct packed {
    logic             stop;    // shift region ended at or before this cell
    logic             valid;   // entry held by the sending cell
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
    logic [DataW-1:0] rd_acc;  // value of the matching entry so far
    logic [DataW-1:0] evk_acc; // key of the tail entry so far
  } link_t;

endpackage

// ----- design/lkvc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency chain
// Holds one key/value pair, compares it against the lookup key, and takes
// its neighbor's entry when it lies inside the shift region of an update.
// ----------------------------------------------------------------------------
module lkvc_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lkvc_pkg::ctl_t  ctl_i,
  input  lkvc_pkg::link_t left_i,
  input  logic            right_valid_i,
  output lkvc_pkg::link_t right_o,
  output logic            match_o,
  output logic            valid_o
);

  logic                       valid_q, valid_d;
  logic [lkvc_pkg::DataW-1:0] key_q, key_d;
  logic [lkvc_pkg::DataW-1:0] value_q, value_d;
  logic                       tail;
  logic                       first_empty;
  logic                       is_last;
  logic                       shift;

  // Compare and locate this cell within the held run
  assign match_o     = valid_q && (key_q == ctl_i.key);
  assign tail        = valid_q && !right_valid_i;
  assign first_empty = !valid_q && left_i.valid;

  // Pick the cell that closes the shift region
  always_comb begin
    if (ctl_i.hit) begin
      is_last = match_o;
    end else if (ctl_i.evict) begin
      is_last = tail;
    end else begin
      is_last = first_empty;
    end
  end

  assign shift = ctl_i.go && !left_i.stop;

  // Take the neighbor's entry inside the shift region, else hold
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (shift) begin
      valid_d = left_i.valid;
      key_d   = left_i.key;
      value_d = left_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  // Pass entry, region end and gathered results to the next cell
  always_comb begin
    right_o.stop    = left_i.stop || is_last;
    right_o.valid   = valid_q;
    right_o.key     = key_q;
    right_o.value   = value_q;
    right_o.rd_acc  = left_i.rd_acc | (match_o ? value_q : '0);
    right_o.evk_acc = left_i.evk_acc | (tail ? key_q : '0);
  end

  assign valid_o = valid_q;

endmodule

// ----- design/lru_key_value_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative LRU key/value cache
// A chain of ENTRIES cells in recency order, most recent first. Every cell
// compares its key in parallel; on an update the cells up to the hit, the
// tail or the first free slot take their neighbor's entry in one step.
// The response word is registered when its request word is taken.
// Throughput: one request word per cycle while the response side takes its words, set by the single-step chain shift.
// Reset: the store comes up empty and capacity reads 16; no clearing pass.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  lkvc_pkg::req_t       req_i,
  // response channel
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i,
  output lkvc_pkg::rsp_t       rsp_o,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [lkvc_pkg::CapW-1:0] cap_q, cap_d;
  logic [lkvc_pkg::CapW-1:0] cap_eff;
  logic [IdxW-1:0]           cap_idx;

  lkvc_pkg::link_t           link [ENTRIES+1];
  lkvc_pkg::link_t           head_link;
  logic [ENTRIES-1:0]        match_vec;
  logic [ENTRIES-1:0]        valid_vec;
  lkvc_pkg::ctl_t            ctl;

  logic                      accept;
  logic                      hit;
  logic                      is_put;
  logic                      evict;
  lkvc_pkg::rsp_t            rsp_d;
  lkvc_pkg::rsp_t            rsp_q;
  logic                      rsp_valid_q, rsp_valid_d;

  // Configuration register
  assign pready = 1'b1;

  always_comb begin
    cap_d = cap_q;
    if (psel && penable && pwrite && (paddr[2] == lkvc_pkg::RegCapacity)) begin
      cap_d = pwdata[lkvc_pkg::CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign prdata = (paddr[2] == lkvc_pkg::RegCapacity) ? {27'd0, cap_q} : '0;

  // Clamp capacity to 1 .. ENTRIES and point at the last slot it allows
  always_comb begin
    cap_eff = cap_q;
    if (cap_q == '0) begin
      cap_eff = 5'd1;
    end else if (int'(cap_q) > int'(ENTRIES)) begin
      cap_eff = lkvc_pkg::CapW'(ENTRIES);
    end
  end

  assign cap_idx = IdxW'(cap_eff - 5'd1);

  // Handshake: a new word enters whenever the response slot frees up
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  assign hit    = |match_vec;
  assign is_put = (req_i.cmd == lkvc_pkg::CMD_PUT);
  assign evict  = is_put && !hit && valid_vec[cap_idx];

  always_comb begin
    ctl.go    = accept && (hit || is_put);
    ctl.hit   = hit;
    ctl.evict = evict;
    ctl.key   = req_i.key;
  end

  // Head of the chain: the entry that lands at most-recent
  always_comb begin
    head_link.stop    = 1'b0;
    head_link.valid   = 1'b1;
    head_link.key     = req_i.key;
    head_link.value   = is_put ? req_i.value : link[ENTRIES].rd_acc;
    head_link.rd_acc  = '0;
    head_link.evk_acc = '0;
  end

  assign link[0] = head_link;

  // Row of cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic right_valid;
    if (g == ENTRIES - 1) begin : g_end
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_valid = valid_vec[g+1];
    end

    lkvc_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_i        (link[g]),
      .right_valid_i (right_valid),
      .right_o       (link[g+1]),
      .match_o       (match_vec[g]),
      .valid_o       (valid_vec[g])
    );
  end

  // Build the response word
  always_comb begin
    rsp_d.hit         = hit;
    rsp_d.evicted     = evict;
    rsp_d.evicted_key = evict ? link[ENTRIES].evk_acc : '0;
    if (is_put) begin
      rsp_d.read_value = '0;
    end else if (hit) begin
      rsp_d.read_value = link[ENTRIES].rd_acc;
    end else begin
      rsp_d.read_value = lkvc_pkg::MissValue;
    end
  end

  // Output register: load on accept, drop once taken
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ----- tb/lru_key_value_cache_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit_tb: self-checking bench for the LRU key/value cache
// Drives get/put request words and checks every response word against an
// in-bench LRU store. The run covers directed lookups, updates and evictions,
// capacity changes (zero, saturated, lowered below the fill level) and random
// traffic over small key pools, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit_tb;

  localparam int unsigned NumEntries = 16;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned ItemsPerPhase = 140;
  localparam logic [2:0]  CapAddr    = {lkvc_pkg::RegCapacity, 2'b00};
  localparam logic [31:0] KeyMin     = 32'h8000_0000;
  localparam logic [31:0] KeyMax     = 32'h7fff_ffff;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_ready_o;
  lkvc_pkg::req_t req_i       = '0;
  logic           rsp_valid_o;
  logic           rsp_ready_i = 1'b0;
  lkvc_pkg::rsp_t rsp_o;
  logic           psel        = 1'b0;
  logic           penable     = 1'b0;
  logic           pwrite      = 1'b0;
  logic [2:0]     paddr       = '0;
  logic [31:0]    pwdata      = '0;
  logic [31:0]    prdata;
  logic           pready;

  // in-bench copy of the store, most recent at index 0
  logic [31:0]  store_key [NumEntries];
  logic [31:0]  store_val [NumEntries];
  int unsigned  store_fill = 0;
  logic [lkvc_pkg::CapW-1:0] capacity_reg = lkvc_pkg::CapReset;

  lkvc_pkg::rsp_t lookup_results [$];
  int unsigned  send_idle_pct  = 0;
  int unsigned  rsp_stall_pct  = 0;
  int unsigned  mismatches     = 0;
  int unsigned  requests_sent  = 0;
  int unsigned  hit_count      = 0;
  int unsigned  evict_count    = 0;
  int unsigned  cap_settings   = 0;
  int unsigned  quiet_cycles   = 0;

  lru_key_value_cache_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Shift entries 0 .. pos-1 one place toward least-recent and put k/v in front
  function automatic void move_to_front(int unsigned pos, logic [31:0] k, logic [31:0] v);
    for (int unsigned i = pos; i > 0; i--) begin
      store_key[i] = store_key[i-1];
      store_val[i] = store_val[i-1];
    end
    store_key[0] = k;
    store_val[0] = v;
  endfunction

  // Apply one request to the store and return the response it gives
  function automatic lkvc_pkg::rsp_t cache_lookup(lkvc_pkg::req_t r);
    lkvc_pkg::rsp_t res;
    int unsigned    pos;
    bit             found;
    int unsigned    limit;
    res   = '0;
    pos   = 0;
    found = 1'b0;
    for (int unsigned i = 0; i < store_fill; i++) begin
      if (!found && store_key[i] == r.key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    limit = (capacity_reg == 0) ? 1 :
            (capacity_reg > NumEntries) ? NumEntries : capacity_reg;
    res.hit = found;
    if (r.cmd == lkvc_pkg::CMD_GET) begin
      if (found) begin
        res.read_value = store_val[pos];
        move_to_front(pos, r.key, store_val[pos]);
      end else begin
        res.read_value = lkvc_pkg::MissValue;
      end
    end else if (found) begin
      move_to_front(pos, r.key, r.value);
    end else begin
      // drop the least-recent entry when full, then insert in front
      if (store_fill >= limit) begin
        res.evicted     = 1'b1;
        res.evicted_key = store_key[store_fill-1];
        store_fill--;
      end
      move_to_front(store_fill, r.key, r.value);
      store_fill++;
    end
    return res;
  endfunction

  // Send one request word; predict its response when it is taken
  task automatic send_request(lkvc_pkg::cmd_e c, logic [31:0] k, logic [31:0] v);
    lkvc_pkg::req_t r;
    lkvc_pkg::rsp_t res;
    r.cmd   = c;
    r.key   = k;
    r.value = v;
    if (send_idle_pct != 0) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        req_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_valid_i <= 1'b1;
    req_i       <= r;
    do @(posedge clk_i); while (!req_ready_o);
    res = cache_lookup(r);
    lookup_results.push_back(res);
    requests_sent++;
    if (res.hit) hit_count++;
    if (res.evicted) evict_count++;
  endtask

  // Drop valid and wait until every response word has come back
  task automatic drain_responses();
    req_valid_i <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CapAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capacity_reg = data[lkvc_pkg::CapW-1:0];
    cap_settings++;
  endtask

  task automatic check_capacity_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CapAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(capacity_reg))
      report_mismatch("capacity readback", prdata, 32'(capacity_reg));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Change capacity with the block idle and confirm the new setting
  task automatic set_capacity(logic [31:0] data);
    drain_responses();
    write_capacity(data);
    check_capacity_readback();
  endtask

  // Random stall of the response side
  always @(posedge clk_i) begin
    rsp_ready_i <= ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // Compare each response word with the oldest prediction
  always @(posedge clk_i) begin
    lkvc_pkg::rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (lookup_results.size() == 0) begin
        report_mismatch("response with no request outstanding", rsp_o.read_value, '0);
      end else begin
        want = lookup_results.pop_front();
        if (rsp_o.hit !== want.hit)
          report_mismatch("hit", 32'(rsp_o.hit), 32'(want.hit));
        if (rsp_o.read_value !== want.read_value)
          report_mismatch("read_value", rsp_o.read_value, want.read_value);
        if (rsp_o.evicted !== want.evicted)
          report_mismatch("evicted", 32'(rsp_o.evicted), 32'(want.evicted));
        if (rsp_o.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", rsp_o.evicted_key, want.evicted_key);
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no handshake in %0d cycles", IdleLimit);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset value of capacity
  task automatic test_register_reset();
    check_capacity_readback();
  endtask

  // Lookups and updates on an empty and partly filled store
  task automatic test_basic_lookup();
    send_request(lkvc_pkg::CMD_GET, 32'd0, $urandom());
    send_request(lkvc_pkg::CMD_PUT, KeyMin, KeyMax);
    send_request(lkvc_pkg::CMD_PUT, KeyMax, KeyMin);
    send_request(lkvc_pkg::CMD_PUT, 32'd0, 32'd0);
    send_request(lkvc_pkg::CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lkvc_pkg::CMD_GET, KeyMin, $urandom());
    send_request(lkvc_pkg::CMD_GET, 32'hffff_ffff, $urandom());
    send_request(lkvc_pkg::CMD_PUT, 32'd0, 32'h5555_5555);
    send_request(lkvc_pkg::CMD_GET, 32'd0, 32'haaaa_aaaa);
    send_request(lkvc_pkg::CMD_GET, 32'd12345, $urandom());
  endtask

  // Capacity lowered below the fill level: evict one, keep the count
  task automatic test_capacity_shrink();
    set_capacity(32'd2);
    send_request(lkvc_pkg::CMD_PUT, 32'd7, 32'd70);
    send_request(lkvc_pkg::CMD_GET, 32'd7, $urandom());
    send_request(lkvc_pkg::CMD_PUT, 32'd8, 32'd80);
    send_request(lkvc_pkg::CMD_GET, KeyMax, $urandom());
  endtask

  // Capacity zero acts as one; values above the store size saturate
  task automatic test_capacity_extremes();
    set_capacity(32'd0);
    send_request(lkvc_pkg::CMD_PUT, 32'd9, 32'd90);
    send_request(lkvc_pkg::CMD_GET, 32'd9, $urandom());
    send_request(lkvc_pkg::CMD_GET, 32'd12345, $urandom());
    set_capacity(32'd31);
    send_request(lkvc_pkg::CMD_PUT, 32'd10, 32'd100);
    send_request(lkvc_pkg::CMD_PUT, 32'd11, 32'd110);
  endtask

  // Random gets and puts over a key pool a little larger than capacity
  task automatic test_random_traffic(logic [31:0] cap_word, int unsigned mode, int unsigned n);
    logic [31:0] key_pool [$];
    int unsigned pool_size;
    int unsigned limit;
    logic [31:0] k;
    set_capacity(cap_word);
    case (mode)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
      default: begin send_idle_pct = 28; rsp_stall_pct = 28; end
    endcase
    limit = (capacity_reg == 0) ? 1 :
            (capacity_reg > NumEntries) ? NumEntries : capacity_reg;
    pool_size = limit + $urandom_range(1, 6);
    for (int unsigned i = 0; i < pool_size; i++) begin
      case ($urandom_range(0, 15))
        0:       key_pool.push_back(KeyMin);
        1:       key_pool.push_back(KeyMax);
        2:       key_pool.push_back(32'hffff_ffff);
        3:       key_pool.push_back(32'd0);
        default: key_pool.push_back($urandom());
      endcase
    end
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(0, pool_size - 1)];
      send_request(lkvc_pkg::cmd_e'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_basic_lookup();
    test_capacity_shrink();
    test_capacity_extremes();
    test_random_traffic(32'd16, 0, ItemsPerPhase);
    test_random_traffic(32'd1, 1, ItemsPerPhase);
    test_random_traffic(32'd4, 2, ItemsPerPhase);
    test_random_traffic(32'hffff_ffff, 3, ItemsPerPhase);
    test_random_traffic({27'($urandom_range(0, 32'h07ff_ffff)), 5'd0}, 0, ItemsPerPhase);
    test_random_traffic(32'd2, 1, ItemsPerPhase);
    test_random_traffic(32'($urandom_range(0, 31)), 2, ItemsPerPhase);
    test_random_traffic(32'd8, 3, ItemsPerPhase);

    send_idle_pct = 0;
    drain_responses();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d requests: %0d hits, %0d evictions, %0d capacity settings",
             requests_sent, hit_count, evict_count, cap_settings);
    $display("Sender gaps and receiver stalls were mixed in; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- lru_key_value_cache_unit.f -----
design/lkvc_pkg.sv
design/lkvc_cell.sv
design/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_tb.sv
